// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on rising edge, async reset aware.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg
// Shared constants and types of the humidity/temperature conversion block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hts_pkg;

	localparam int TICK_W = 16;
	localparam int TEMP_W = 13;
	localparam int HUM_W  = 10;
	localparam int SUM_W  = 40;
	localparam int U_W    = 24;
	localparam int RCP_W  = 21;
	localparam int PROD_W = U_W + RCP_W;
	localparam int RCP_SH = 34;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH  = 8'd3;

	localparam logic [TICK_W-1:0] VALID_T_TICKS = 16'd4300;
	localparam logic [TICK_W-1:0] T_OFFSET      = 16'd4200;
	localparam logic signed [TICK_W:0] T_REF    = 17'sd6700;
	localparam logic [19:0] RH_LIN_BASE          = 20'd1000;
	localparam logic [34:0] LIN_COEF             = 35'd405000;
	localparam logic [31:0] DIV10_RCP            = 32'd52429;
	localparam int          DIV10_SH             = 19;
	localparam logic signed [SUM_W-1:0] HUM_OFS  = 40'sd40000000;
	localparam logic signed [SUM_W-1:0] HUM_MAX  = 40'sd1000000000;
	localparam logic signed [SUM_W-1:0] HUM_MIN  = 40'sd1000000;
	// 1e6 = 64 * 15625; the 64 is taken off by a shift
	localparam int          PRE_SH              = 6;
	localparam logic [RCP_W-1:0] DIV_RCP        = 21'd1099511;
	localparam logic [U_W-1:0]   DIV_K          = 24'd15625;

	localparam logic [8:0] TEMP_LOW_RST  = 9'd0;
	localparam logic [8:0] TEMP_HIGH_RST = 9'd50;
	localparam logic [6:0] HUM_LOW_RST   = 7'd0;
	localparam logic [6:0] HUM_HIGH_RST  = 7'd100;

	typedef struct packed {
		logic              reading_ok;
		logic [TEMP_W-1:0] temp_tenths;
	} side_t;

endpackage

// ----- hw/rtl/hts_hum_div.sv -----
// ----------------------------------------------------------------------------
// hts_hum_div
// Clamp of the scaled humidity sum and division by 1e6 to tenths; 3 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_hum_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_take,
	input  logic signed [hts_pkg::SUM_W-1:0]    sum,
	input  hts_pkg::side_t                      side_in,
	output logic                                out_valid,
	input  logic                                out_take,
	output logic [hts_pkg::HUM_W-1:0]           hum_tenths,
	output hts_pkg::side_t                      side_out
);

	logic v_d1, v_d2, v_d3;
	logic en_d1, en_d2, en_d3;
	logic [hts_pkg::U_W-1:0]    u_d1, u_d2;
	logic [hts_pkg::PROD_W-1:0] prod_d2;
	logic [hts_pkg::HUM_W-1:0]  q_d3;
	hts_pkg::side_t side_d1, side_d2, side_d3;

	logic signed [hts_pkg::SUM_W-1:0] clamp_c;
	logic [hts_pkg::HUM_W:0]          q0_c;
	logic [hts_pkg::U_W-1:0]          r_c;
	logic [hts_pkg::HUM_W:0]          q_c;

	assign en_d3   = !v_d3 || out_take;
	assign en_d2   = !v_d2 || en_d3;
	assign en_d1   = !v_d1 || en_d2;
	assign in_take = en_d1;

	always_comb begin
		if (sum > hts_pkg::HUM_MAX) begin
			clamp_c = hts_pkg::HUM_MAX;
		end else if (sum < hts_pkg::HUM_MIN) begin
			clamp_c = hts_pkg::HUM_MIN;
		end else begin
			clamp_c = sum;
		end
	end

	assign q0_c = prod_d2[hts_pkg::PROD_W-1:hts_pkg::RCP_SH];
	assign r_c  = u_d2 - hts_pkg::U_W'(q0_c * hts_pkg::DIV_K);
	assign q_c  = (r_c >= hts_pkg::DIV_K) ? q0_c + 1'b1 : q0_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			v_d3 <= 1'b0;
		end else begin
			if (en_d1) v_d1 <= in_valid;
			if (en_d2) v_d2 <= v_d1;
			if (en_d3) v_d3 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_d1 && in_valid) begin
			u_d1    <= clamp_c[hts_pkg::PRE_SH+hts_pkg::U_W-1:hts_pkg::PRE_SH];
			side_d1 <= side_in;
		end
		if (en_d2 && v_d1) begin
			u_d2    <= u_d1;
			prod_d2 <= hts_pkg::PROD_W'(u_d1) * hts_pkg::PROD_W'(hts_pkg::DIV_RCP);
			side_d2 <= side_d1;
		end
		if (en_d3 && v_d2) begin
			q_d3    <= q_c[hts_pkg::HUM_W-1:0];
			side_d3 <= side_d2;
		end
	end

	assign out_valid  = v_d3;
	assign hum_tenths = q_d3;
	assign side_out   = side_d3;

	`ASSERT_IMPLY(a_rcp_err, clk, arst_n, v_d2, r_c < (hts_pkg::DIV_K << 1), "quotient off by more than one")
	`ASSERT_NEXT(a_d3_hold, clk, arst_n, v_d3 && !out_take, v_d3 && $stable(q_d3), "stage 3 lost a beat")

endmodule

// ----- hw/rtl/humidity_temp_sensor_convert_alarm_top.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_sensor_convert_alarm_top
// Sensor word to temperature/humidity tenths with four limit alarms.
//
//  channel  handshake              payload
//  in       in_valid / in_stall    raw_word
//  out      out_valid / out_stall  reading_valid, temp_tenths, humidity_tenths,
//                                  temp_too_low/high, humidity_too_low/high
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; the stages in order are products, sum,
// clamp, reciprocal multiply, quotient correction, alarm compare.
// Stalls back up through per-stage enables; bubbles are squeezed out.
// arst_n clears stage valids and loads limit reset values; cfg_ready is held high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module humidity_temp_sensor_convert_alarm_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       raw_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              reading_valid,
	output logic [hts_pkg::TEMP_W-1:0]        temp_tenths,
	output logic [hts_pkg::HUM_W-1:0]         humidity_tenths,
	output logic                              temp_too_low,
	output logic                              temp_too_high,
	output logic                              humidity_too_low,
	output logic                              humidity_too_high,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hts_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [8:0] temp_low_q, temp_high_q;
	logic [6:0] hum_low_q, hum_high_q;

	logic [hts_pkg::TICK_W-1:0] rh_c, t_c, tx_c;
	logic                       rv_c;
	logic signed [hts_pkg::TICK_W:0] tdiff_c;
	logic [19:0]                rhw_c;

	logic v_s1, v_s2, en_s1, en_s2, en_o;
	logic rv_s1;
	logic [31:0] sq_s1, tmul_s1;
	logic [34:0] lin_s1;
	logic signed [37:0] cross_s1;
	logic [39:0] sq28_c;
	logic signed [hts_pkg::SUM_W-1:0] sum_s2;
	hts_pkg::side_t side_s2, side_div;

	logic div_take, div_valid;
	logic [hts_pkg::HUM_W-1:0] hum_div;

	logic signed [13:0] tlo10_c, thi10_c;
	logic signed [13:0] temp_sx_c;
	logic [10:0] hlo10_c, hhi10_c;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= hts_pkg::TEMP_LOW_RST;
			temp_high_q <= hts_pkg::TEMP_HIGH_RST;
			hum_low_q   <= hts_pkg::HUM_LOW_RST;
			hum_high_q  <= hts_pkg::HUM_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hts_pkg::REG_TEMP_LOW:  temp_low_q  <= cfg_data[8:0];
				hts_pkg::REG_TEMP_HIGH: temp_high_q <= cfg_data[8:0];
				hts_pkg::REG_HUM_LOW:   hum_low_q   <= cfg_data[6:0];
				hts_pkg::REG_HUM_HIGH:  hum_high_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// stage enables
	assign en_o     = !out_valid || !out_stall;
	assign en_s2    = !v_s2 || div_take;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// unpack, bytes swapped within each half
	assign rh_c    = {raw_word[23:16], raw_word[31:24]};
	assign t_c     = {raw_word[7:0], raw_word[15:8]};
	assign rv_c    = t_c >= hts_pkg::VALID_T_TICKS;
	assign tx_c    = rv_c ? t_c - hts_pkg::T_OFFSET : '0;
	assign tdiff_c = $signed({1'b0, t_c}) - hts_pkg::T_REF;
	assign rhw_c   = hts_pkg::RH_LIN_BASE + {1'b0, rh_c, 3'b000};

	assign sq28_c  = {3'b000, sq_s1, 5'b00000} - {6'b000000, sq_s1, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) v_s1      <= in_valid;
			if (en_s2) v_s2      <= v_s1;
			if (en_o)  out_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			rv_s1    <= rv_c;
			sq_s1    <= 32'(rh_c) * 32'(rh_c);
			lin_s1   <= 35'(rh_c) * hts_pkg::LIN_COEF;
			tmul_s1  <= 32'(tx_c) * hts_pkg::DIV10_RCP;
			cross_s1 <= 38'(tdiff_c) * 38'($signed({1'b0, rhw_c}));
		end
		if (en_s2 && v_s1) begin
			sum_s2 <= $signed({5'b00000, lin_s1}) - $signed(sq28_c)
			        + 40'(cross_s1) - hts_pkg::HUM_OFS;
			side_s2.reading_ok  <= rv_s1;
			side_s2.temp_tenths <= tmul_s1[hts_pkg::DIV10_SH+hts_pkg::TEMP_W-1:hts_pkg::DIV10_SH];
		end
	end

	hts_hum_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s2),
		.in_take    (div_take),
		.sum        (sum_s2),
		.side_in    (side_s2),
		.out_valid  (div_valid),
		.out_take   (en_o),
		.hum_tenths (hum_div),
		.side_out   (side_div)
	);

	// alarm compare
	assign tlo10_c   = 14'($signed(temp_low_q)) * 14'sd10;
	assign thi10_c   = 14'($signed(temp_high_q)) * 14'sd10;
	assign temp_sx_c = $signed({1'b0, side_div.temp_tenths});
	assign hlo10_c   = 11'(hum_low_q) * 11'd10;
	assign hhi10_c   = 11'(hum_high_q) * 11'd10;

	always_ff @(posedge clk) begin
		if (en_o && div_valid) begin
			reading_valid <= side_div.reading_ok;
			if (side_div.reading_ok) begin
				temp_tenths       <= side_div.temp_tenths;
				humidity_tenths   <= hum_div;
				temp_too_low      <= temp_sx_c < tlo10_c;
				temp_too_high     <= temp_sx_c > thi10_c;
				humidity_too_low  <= 11'(hum_div) < hlo10_c;
				humidity_too_high <= 11'(hum_div) > hhi10_c;
			end else begin
				temp_tenths       <= '0;
				humidity_tenths   <= '0;
				temp_too_low      <= 1'b0;
				temp_too_high     <= 1'b0;
				humidity_too_low  <= 1'b0;
				humidity_too_high <= 1'b0;
			end
		end
	end

	`ASSERT_IMPLY(a_invalid_zero, clk, arst_n, out_valid && !reading_valid, temp_tenths == '0 && humidity_tenths == '0 && !temp_too_low && !temp_too_high && !humidity_too_low && !humidity_too_high, "invalid reading with nonzero fields")
	`ASSERT_IMPLY(a_hum_range, clk, arst_n, out_valid && reading_valid, humidity_tenths >= 10'd1 && humidity_tenths <= 10'd1000, "humidity outside clamp")
	`ASSERT_IMPLY(a_temp_range, clk, arst_n, out_valid && reading_valid, temp_tenths >= 13'd10 && temp_tenths <= 13'd6133, "temperature outside range")

endmodule
